// ===== rtl/core/cfir_pkg.sv =====
// Shared types and constants of the strided-tap complex FIR filter.
// Used by the register file, controller, datapath and top level; depends on nothing.
package cfir_pkg;

	// Store geometry
	localparam int MAX_TAPS = 64;
	localparam int TAP_AW   = $clog2(MAX_TAPS);
	localparam int CNT_W    = TAP_AW + 1;

	// Field widths
	localparam int SMP_W  = 16;
	localparam int PAIR_W = 2 * SMP_W;
	localparam int PROD_W = 2 * SMP_W;
	localparam int ACC_W  = 40;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_TAP_COUNT  = 2'd0;
	localparam logic [1:0] REG_TAP_STRIDE = 2'd1;
	localparam logic [1:0] REG_FIRST_TAP  = 2'd2;
	localparam logic [1:0] REG_COMPLEX    = 2'd3;

	// Register reset values
	localparam logic [6:0] RST_TAP_COUNT  = 7'd16;
	localparam logic [6:0] RST_TAP_STRIDE = 7'd1;
	localparam logic [5:0] RST_FIRST_TAP  = 6'd0;
	localparam logic       RST_COMPLEX    = 1'b1;

	// Item kinds carried on tuser
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	typedef struct packed {
		logic [6:0] tap_count;
		logic [6:0] tap_stride;
		logic [5:0] first_tap;
		logic       complex_taps;
	} cfir_cfg_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_re;
		logic signed [SMP_W-1:0] sample_im;
		logic [5:0]              tap_index;
		logic signed [SMP_W-1:0] tap_re;
		logic signed [SMP_W-1:0] tap_im;
	} cfir_in_t;

	// Controller to datapath
	typedef struct packed {
		logic              push;     // write sample into delay line, clear accumulator
		logic              load;     // write one tap
		logic              issue;    // read one term into the MAC pipeline
		logic [TAP_AW-1:0] tap_idx;  // tap k
		logic [TAP_AW-1:0] age;      // sample age n-1-k, n = tap_count capped at MAX_TAPS
		logic              publish;  // move accumulator into the output register
	} cfir_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic busy;      // MAC pipeline holds terms
		logic out_free;  // output register can take a result this cycle
	} cfir_sts_t;

endpackage

// ===== rtl/core/cfir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used for the sample delay line and the tap store.
module cfir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/cfir_regs.sv =====
// APB-style configuration registers of the complex FIR filter.
// Depends on cfir_pkg for register indexes, reset values and the config struct.
module cfir_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfir_pkg::cfir_cfg_t cfg
);
	import cfir_pkg::*;

	cfir_cfg_t cfg_q;
	logic      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_count    <= RST_TAP_COUNT;
			cfg_q.tap_stride   <= RST_TAP_STRIDE;
			cfg_q.first_tap    <= RST_FIRST_TAP;
			cfg_q.complex_taps <= RST_COMPLEX;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_TAP_COUNT:  cfg_q.tap_count    <= pwdata[6:0];
				REG_TAP_STRIDE: cfg_q.tap_stride   <= pwdata[6:0];
				REG_FIRST_TAP:  cfg_q.first_tap    <= pwdata[5:0];
				REG_COMPLEX:    cfg_q.complex_taps <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (paddr[3:2])
			REG_TAP_COUNT:  prdata = {25'd0, cfg_q.tap_count};
			REG_TAP_STRIDE: prdata = {25'd0, cfg_q.tap_stride};
			REG_FIRST_TAP:  prdata = {26'd0, cfg_q.first_tap};
			REG_COMPLEX:    prdata = {31'd0, cfg_q.complex_taps};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/core/cfir_ctrl.sv =====
// Controller of the complex FIR filter: accepts items and walks the selected taps.
// Depends on cfir_pkg; drives the datapath by cfir_cmd_t and reads cfir_sts_t.
module cfir_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_op,
	output logic                in_ready,
	input  cfir_pkg::cfir_cfg_t cfg,
	input  cfir_pkg::cfir_sts_t sts,
	output cfir_pkg::cfir_cmd_t cmd
);
	import cfir_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]        state_q;
	logic [TAP_AW-1:0] k_q;
	logic [CNT_W-1:0]  n_w;
	logic [CNT_W-1:0]  stride_w;
	logic [CNT_W:0]    k_next_w;
	logic [CNT_W-1:0]  age_w;
	logic              accept_w;
	logic              push_w;

	// Effective tap count and stride
	assign n_w      = (cfg.tap_count > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : cfg.tap_count;
	assign stride_w = (cfg.tap_stride == '0) ? CNT_W'(1) : cfg.tap_stride;
	assign k_next_w = {2'b00, k_q} + {1'b0, stride_w};
	assign age_w    = n_w - CNT_W'(1) - {1'b0, k_q};

	assign in_ready = (state_q == ST_IDLE);
	assign accept_w = in_valid & in_ready;
	assign push_w   = accept_w & (in_op == OP_SAMPLE);

	// Commands
	always_comb begin
		cmd.push    = push_w;
		cmd.load    = accept_w & (in_op == OP_LOAD);
		cmd.issue   = (state_q == ST_RUN);
		cmd.tap_idx = k_q;
		cmd.age     = age_w[TAP_AW-1:0];
		cmd.publish = (state_q == ST_DRAIN) & ~sts.busy & sts.out_free;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (push_w) begin
						k_q <= cfg.first_tap;
						if ({1'b0, cfg.first_tap} < n_w) begin
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_RUN: begin
					if (k_next_w >= {1'b0, n_w}) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_next_w[TAP_AW-1:0];
					end
				end
				ST_DRAIN: begin
					if (cmd.publish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Tap walk never leaves the taps in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ({1'b0, k_q} < n_w))
		else $error("tap index beyond tap count while walking");

	// An accepted sample item always starts a filter pass (RUN or DRAIN)
	assert property (@(posedge clk) disable iff (!arst_n)
		push_w |=> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("sample accepted without starting a filter pass");

endmodule

// ===== rtl/core/cfir_dp.sv =====
// Datapath of the complex FIR filter: delay line, tap store, shared complex MAC.
// Depends on cfir_pkg and cfir_ram; commanded by cfir_ctrl.
module cfir_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  cfir_pkg::cfir_in_t  item,
	input  cfir_pkg::cfir_cfg_t cfg,
	input  cfir_pkg::cfir_cmd_t cmd,
	output cfir_pkg::cfir_sts_t sts,
	output logic                out_vld,
	input  logic                out_rdy,
	output logic [39:0]         out_re,
	output logic [39:0]         out_im
);
	import cfir_pkg::*;

	logic [TAP_AW-1:0]   wr_ptr_q;
	logic [CNT_W-1:0]    fill_q;
	logic [MAX_TAPS-1:0] tap_vld_q;
	logic [TAP_AW-1:0]   smp_raddr;
	logic [PAIR_W-1:0]   smp_rd;
	logic [PAIR_W-1:0]   tap_rd;

	logic                    vld_s1, ok_smp_s1, ok_tap_s1;
	logic signed [SMP_W-1:0] xr_w, xi_w, hr_w, hi_w;
	logic                    vld_s2;
	logic signed [PROD_W-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [PROD_W:0]   term_re_w, term_im_w;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_im_q;
	logic                     out_vld_q;
	logic [ACC_W-1:0]         out_re_q, out_im_q;

	// Delay line as a circular buffer: age a sits at wr_ptr - 1 - a
	assign smp_raddr = wr_ptr_q - TAP_AW'(1) - cmd.age;

	cfir_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_TAPS)) u_smp_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (wr_ptr_q),
		.wdata ({item.sample_im, item.sample_re}),
		.raddr (smp_raddr),
		.rdata (smp_rd)
	);

	cfir_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_TAPS)) u_tap_ram (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (item.tap_index[TAP_AW-1:0]),
		.wdata ({item.tap_im, item.tap_re}),
		.raddr (cmd.tap_idx),
		.rdata (tap_rd)
	);

	// Write pointer, fill count and tap valid bits (unwritten entries read as zero)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			fill_q    <= '0;
			tap_vld_q <= '0;
		end else begin
			if (cmd.push) begin
				wr_ptr_q <= wr_ptr_q + TAP_AW'(1);
				if (fill_q != CNT_W'(MAX_TAPS)) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			if (cmd.load) begin
				tap_vld_q[item.tap_index[TAP_AW-1:0]] <= 1'b1;
			end
		end
	end

	// Stage 1: read data arrives with its valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			ok_smp_s1 <= 1'b0;
			ok_tap_s1 <= 1'b0;
		end else begin
			vld_s1    <= cmd.issue;
			ok_smp_s1 <= ({1'b0, cmd.age} < fill_q);
			ok_tap_s1 <= tap_vld_q[cmd.tap_idx];
		end
	end

	// Operand select; real mode is a complex tap with zero imaginary part
	assign xr_w = ok_smp_s1 ? smp_rd[SMP_W-1:0]      : '0;
	assign xi_w = ok_smp_s1 ? smp_rd[PAIR_W-1:SMP_W] : '0;
	assign hr_w = ok_tap_s1 ? tap_rd[SMP_W-1:0]      : '0;
	assign hi_w = (ok_tap_s1 && cfg.complex_taps) ? tap_rd[PAIR_W-1:SMP_W] : '0;

	// Stage 2: four partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_rr_s2 <= xr_w * hr_w;
		p_ii_s2 <= xi_w * hi_w;
		p_ri_s2 <= xr_w * hi_w;
		p_ir_s2 <= xi_w * hr_w;
	end

	// Accumulate, wrapping at the result width
	assign term_re_w = (PROD_W+1)'(p_rr_s2) - (PROD_W+1)'(p_ii_s2);
	assign term_im_w = (PROD_W+1)'(p_ri_s2) + (PROD_W+1)'(p_ir_s2);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			acc_q    <= '0;
			acc_im_q <= '0;
		end else if (vld_s2) begin
			acc_q    <= acc_q + ACC_W'(term_re_w);
			acc_im_q <= acc_im_q + ACC_W'(term_im_w);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.publish) begin
			out_vld_q <= 1'b1;
		end else if (out_rdy) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_re_q <= acc_q;
			out_im_q <= acc_im_q;
		end
	end

	assign out_vld      = out_vld_q;
	assign out_re       = out_re_q;
	assign out_im       = out_im_q;
	assign sts.busy     = vld_s1 | vld_s2;
	assign sts.out_free = ~out_vld_q | out_rdy;

	// Result only leaves once every term has reached the accumulator
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!vld_s1 && !vld_s2 && !cmd.issue))
		else $error("result published with terms still in the MAC");

	// No new sample or tap while terms are in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push || cmd.load) |-> (!vld_s1 && !vld_s2))
		else $error("store written while MAC pipeline busy");

	// Fill count saturates at the store depth
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_TAPS))
		else $error("delay line fill count overflow");

endmodule

// ===== rtl/core/complex_fir_filter_strided_taps_unit.sv =====
// Top level of the strided-tap complex FIR filter: stream ports and APB config.
// Depends on cfir_pkg, cfir_regs, cfir_ctrl, cfir_dp and cfir_ram.
//
// One input item at a time; a tap load writes one tap store entry. A sample
// item is filtered by one shared complex multiply-accumulate that takes one
// selected tap per cycle. The summed taps are first_tap, first_tap+tap_stride,
// ... below tap_count (at most 64 taps). The result sits in an output register,
// so the next item is taken while it waits; a further result waits inside until
// that register is free. Delay line and tap store are 64-entry RAMs; reset
// makes them read as zero at once.
module complex_fir_filter_strided_taps_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // sample_re, sample_im, tap_index, tap_re, tap_im, 2'b0
	input  logic [0:0]  s_tuser,  // operation
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // result_re, result_im
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cfir_pkg::*;

	cfir_cfg_t   cfg;
	cfir_cmd_t   cmd;
	cfir_sts_t   sts;
	cfir_in_t    item;
	logic [39:0] res_re, res_im;

	// Unpack input transfer
	assign item.sample_re = s_tdata[15:0];
	assign item.sample_im = s_tdata[31:16];
	assign item.tap_index = s_tdata[37:32];
	assign item.tap_re    = s_tdata[53:38];
	assign item.tap_im    = s_tdata[69:54];

	cfir_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cfir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser[0]),
		.in_ready (s_tready),
		.cfg      (cfg),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfir_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cfg     (cfg),
		.cmd     (cmd),
		.sts     (sts),
		.out_vld (m_tvalid),
		.out_rdy (m_tready),
		.out_re  (res_re),
		.out_im  (res_im)
	);

	assign m_tdata = {res_im, res_re};

endmodule
